FILE: rtl/core/pfs_pkg.sv
package pfs_pkg;

    localparam int CW = 24;
    localparam int WW = 56;
    localparam int WMAG = 28;
    localparam int MAX_POINTS = 16;

    typedef enum logic [1:0] {
        OP_SQRT = 2'b01,
        OP_DIV  = 2'b10
    } math_op_t;

    typedef struct packed {
        logic            start;
        math_op_t        op;
        logic [WW-1:0]   a;
        logic [WW-1:0]   b;
    } math_req_t;

    typedef struct packed {
        logic            done;
        logic [WW-1:0]   q;
    } math_rsp_t;

    localparam logic [2:0] REG_MAX_SPEED   = 3'd0;
    localparam logic [2:0] REG_MAX_FORCE   = 3'd1;
    localparam logic [2:0] REG_PATH_LENGTH = 3'd2;
    localparam logic [2:0] REG_START_X     = 3'd3;
    localparam logic [2:0] REG_START_Y     = 3'd4;

endpackage

FILE: rtl/core/pfs_math.sv
module pfs_math (
    input  logic                aclk,
    input  logic                aresetn,
    input  pfs_pkg::math_req_t  req,
    output pfs_pkg::math_rsp_t  rsp
);

    localparam int W = pfs_pkg::WW;

    logic                 busy_reg;
    logic                 sqrt_reg;
    logic [6:0]           cnt_reg;
    logic [W-1:0]         rem_reg;
    logic [W-1:0]         num_reg;
    logic [W-1:0]         den_reg;
    logic [W-1:0]         q_reg;
    logic                 done_reg;
    logic [W+1:0]         trial;
    logic [W+1:0]         rem2;
    logic [W+1:0]         rs;

    always_comb begin
        rem2  = {rem_reg, num_reg[W-1:W-2]};
        rs    = {q_reg[W-1:0], 2'b01};
        if (sqrt_reg) begin
            trial = rem2 - rs;
        end else begin
            trial = {1'b0, rem_reg, num_reg[W-1]} - {2'b00, den_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                sqrt_reg <= (req.op == pfs_pkg::OP_SQRT);
                cnt_reg  <= (req.op == pfs_pkg::OP_SQRT) ? 7'(W / 2) : 7'(W);
                rem_reg  <= '0;
                num_reg  <= req.a;
                den_reg  <= req.b;
                q_reg    <= '0;
            end else if (busy_reg) begin
                if (sqrt_reg) begin
                    num_reg <= {num_reg[W-3:0], 2'b00};
                    if (!trial[W+1]) begin
                        rem_reg <= trial[W-1:0];
                        q_reg   <= {q_reg[W-2:0], 1'b1};
                    end else begin
                        rem_reg <= rem2[W-1:0];
                        q_reg   <= {q_reg[W-2:0], 1'b0};
                    end
                end else begin
                    num_reg <= {num_reg[W-2:0], 1'b0};
                    if (!trial[W+1]) begin
                        rem_reg <= trial[W-1:0];
                        q_reg   <= {q_reg[W-2:0], 1'b1};
                    end else begin
                        rem_reg <= {rem_reg[W-2:0], num_reg[W-1]};
                        q_reg   <= {q_reg[W-2:0], 1'b0};
                    end
                end
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.q    = q_reg;

endmodule

FILE: rtl/core/path_following_steering_step.sv
// Channel   | Dir | Fields (tdata low bit up)
// s_axis    | in  | tuser: op; tdata: point_index, point_x, point_y (+4 pad)
// m_axis    | out | tdata: location_x/y, velocity_x/y, distance_to_path; tuser: steered
// apb       | in  | max_speed, max_force, path_length, start_x, start_y
// A point write passes through the write state, which sends a result; the next item waits for it to leave.
// A tick runs its square roots and divides one at a time on the shared unit, with four
// roots, five divides and two point reads per segment, over up to 16 points in use.
// Reset is synchronous; state returns to start values. Input stalls while a tick or write runs
// or a result waits; the result register parts the two sides.
module path_following_steering_step #(
    parameter int FRAC_BITS  = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // point_index[3:0], point_x, point_y, zero pad
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [119:0] m_tdata,  // location_x, location_y, velocity_x, velocity_y,
                                   // distance_to_path
    output logic        m_tuser,   // steered
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int W  = pfs_pkg::WW;
    localparam int MW = pfs_pkg::WMAG;
    localparam int NP = pfs_pkg::MAX_POINTS;
    localparam int AW = (NP > 1) ? $clog2(NP) : 1;
    localparam int IW = AW + 1;
    localparam logic signed [W-1:0] ONE = W'(1) <<< FRAC_BITS;

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_VM   = 11'b00000000010,
        S_PRED = 11'b00000000100,
        S_RDA  = 11'b00000001000,
        S_RDB  = 11'b00000010000,
        S_SEG  = 11'b00000100000,
        S_SEEK = 11'b00001000000,
        S_STR  = 11'b00010000000,
        S_FIN  = 11'b00100000000,
        S_OUT  = 11'b01000000000,
        S_WR   = 11'b10000000000
    } state_t;

    state_t state_reg;

    logic [11:0] max_speed_reg, max_force_reg;
    logic [4:0]  path_len_reg;
    logic [23:0] start_x_reg, start_y_reg;

    logic signed [W-1:0] lx_reg, ly_reg, vx_reg, vy_reg;
    logic signed [W-1:0] px_reg, py_reg, ax_reg, ay_reg, bx_reg, by_reg;
    logic signed [W-1:0] nx_reg, ny_reg, len_reg, t_reg, m1_reg;
    logic signed [W-1:0] rec_reg, tx_reg, ty_reg, dx_reg, dy_reg, qd_reg;
    logic signed [W-1:0] sx_reg, sy_reg;
    logic [4:0]  sub_reg;
    logic [IW-1:0] seg_reg;
    logic        steer_reg;
    logic        go_reg;

    logic [47:0] mem [NP];
    logic [47:0] rd_reg;
    logic [AW-1:0] rd_addr;

    logic [119:0] out_data_reg;
    logic        out_user_reg, out_valid_reg;

    pfs_pkg::math_req_t mreq;
    pfs_pkg::math_rsp_t mrsp;

    pfs_math u_math (.aclk(aclk), .aresetn(aresetn), .req(mreq), .rsp(mrsp));

    logic [IW-1:0] npts;
    assign npts = (path_len_reg > 5'(NP)) ? IW'(NP) : IW'(path_len_reg);

    // signed magnitude helpers
    function automatic logic [W-1:0] absv(input logic signed [W-1:0] v);
        absv = v[W-1] ? W'(-v) : W'(v);
    endfunction

    function automatic logic signed [W-1:0] clampv(input logic signed [W-1:0] v,
                                                   input logic [11:0] lim);
        logic signed [W-1:0] l;
        l = W'(signed'({1'b0, lim}));
        if (v > l) clampv = l;
        else if (v < -l) clampv = -l;
        else clampv = v;
    endfunction

    function automatic logic signed [W-1:0] mulw(input logic signed [W-1:0] x,
                                                 input logic signed [W-1:0] y);
        logic signed [MW-1:0] xn, yn;
        xn = MW'(x);
        yn = MW'(y);
        mulw = xn * yn;
    endfunction

    function automatic logic [W-1:0] sq2(input logic signed [W-1:0] x,
                                         input logic signed [W-1:0] y);
        sq2 = mulw(x, x) + mulw(y, y);
    endfunction

    // current sub-operation operands
    logic signed [W-1:0] sa, sb;
    logic                is_sqrt;
    logic                neg_q;
    logic [W-1:0]        q_s;

    always_comb begin
        sa = '0; sb = W'(1); is_sqrt = 1'b0; neg_q = 1'b0;
        unique case (state_reg)
            S_VM: begin
                is_sqrt = 1'b1; sa = sq2(vx_reg, vy_reg);
            end
            S_PRED: begin
                sa = (sub_reg == 5'd0) ? vx_reg * (30 * ONE) : vy_reg * (30 * ONE);
                sb = m1_reg;
            end
            S_SEG: begin
                unique case (sub_reg)
                    5'd0: begin is_sqrt = 1'b1; sa = sq2(bx_reg - ax_reg, by_reg - ay_reg); end
                    5'd1: begin
                        sa = mulw(bx_reg - ax_reg, px_reg - ax_reg)
                           + mulw(by_reg - ay_reg, py_reg - ay_reg);
                        sb = len_reg;
                    end
                    5'd2: begin sa = mulw(bx_reg - ax_reg, t_reg); sb = len_reg; end
                    5'd3: begin sa = mulw(by_reg - ay_reg, t_reg); sb = len_reg; end
                    5'd4: begin is_sqrt = 1'b1; sa = sq2(nx_reg - ax_reg, ny_reg - ay_reg); end
                    5'd5: begin is_sqrt = 1'b1; sa = sq2(nx_reg - bx_reg, ny_reg - by_reg); end
                    5'd6: begin is_sqrt = 1'b1; sa = sq2(px_reg - nx_reg, py_reg - ny_reg); end
                    5'd7: begin sa = (bx_reg - ax_reg) * (5 * ONE); sb = len_reg; end
                    5'd8: begin sa = (by_reg - ay_reg) * (5 * ONE); sb = len_reg; end
                    default: ;
                endcase
            end
            S_SEEK: begin
                if (sub_reg == 5'd0) begin
                    is_sqrt = 1'b1;
                    sa = sq2(tx_reg + dx_reg - lx_reg, ty_reg + dy_reg - ly_reg);
                end else if (sub_reg == 5'd1) begin
                    sa = mulw(tx_reg + dx_reg - lx_reg, W'(max_speed_reg));
                    sb = qd_reg;
                end else begin
                    sa = mulw(ty_reg + dy_reg - ly_reg, W'(max_speed_reg));
                    sb = qd_reg;
                end
            end
            default: ;
        endcase
        neg_q = !is_sqrt && sa[W-1];
        mreq.start = go_reg;
        mreq.op = is_sqrt ? pfs_pkg::OP_SQRT : pfs_pkg::OP_DIV;
        mreq.a  = is_sqrt ? sa : absv(sa);
        mreq.b  = sb;
        q_s     = neg_q ? W'(-mrsp.q) : mrsp.q;
    end

    logic s_hs;
    assign s_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign s_hs = s_tvalid && s_tready;

    always_comb begin
        rd_addr = seg_reg[AW-1:0];
        if (state_reg == S_RDA) rd_addr = AW'(seg_reg + IW'(1));
    end

    always_ff @(posedge aclk) begin
        rd_reg <= mem[rd_addr];
        if (s_hs && !s_tuser && (5'(s_tdata[3:0]) < 5'(NP))) begin
            mem[s_tdata[AW-1:0]] <= s_tdata[51:4];
        end
    end

    logic signed [W-1:0] nvx, nvy;
    always_comb begin
        nvx = clampv(vx_reg + sx_reg, max_speed_reg);
        nvy = clampv(vy_reg + sy_reg, max_speed_reg);
    end

    logic pwr;
    assign pwr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb begin
        case (paddr[4:2])
            pfs_pkg::REG_MAX_SPEED:   prdata = {20'd0, max_speed_reg};
            pfs_pkg::REG_MAX_FORCE:   prdata = {20'd0, max_force_reg};
            pfs_pkg::REG_PATH_LENGTH: prdata = {27'd0, path_len_reg};
            pfs_pkg::REG_START_X:     prdata = {8'd0, start_x_reg};
            pfs_pkg::REG_START_Y:     prdata = {8'd0, start_y_reg};
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_speed_reg <= 12'd512;
            max_force_reg <= 12'd26;
            path_len_reg  <= 5'd2;
            start_x_reg   <= 24'd256256;
            start_y_reg   <= 24'd166656;
        end else if (pwr) begin
            case (paddr[4:2])
                pfs_pkg::REG_MAX_SPEED:   max_speed_reg <= pwdata[11:0];
                pfs_pkg::REG_MAX_FORCE:   max_force_reg <= pwdata[11:0];
                pfs_pkg::REG_PATH_LENGTH: path_len_reg  <= pwdata[4:0];
                pfs_pkg::REG_START_X:     start_x_reg   <= pwdata[23:0];
                pfs_pkg::REG_START_Y:     start_y_reg   <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            go_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            lx_reg <= W'(signed'(start_x_reg));
            ly_reg <= W'(signed'(start_y_reg));
            vx_reg <= -W'(signed'({1'b0, max_speed_reg}));
            vy_reg <= '0;
        end else begin
            go_reg <= 1'b0;
            if (out_valid_reg && m_tready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: if (s_hs) begin
                    if (!s_tuser) state_reg <= S_WR;
                    else begin
                        state_reg <= S_VM; sub_reg <= '0; go_reg <= 1'b1;
                        px_reg <= lx_reg; py_reg <= ly_reg;
                        rec_reg <= W'(1000000) * ONE;
                        tx_reg <= '0; ty_reg <= '0; dx_reg <= '0; dy_reg <= '0;
                        sx_reg <= '0; sy_reg <= '0; steer_reg <= 1'b0;
                        seg_reg <= '0;
                    end
                end
                S_WR: begin
                    out_data_reg <= {24'd0, vy_reg[23:0], vx_reg[23:0],
                                     ly_reg[23:0], lx_reg[23:0]};
                    out_user_reg <= 1'b0;
                    out_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_VM: if (mrsp.done) begin
                    m1_reg <= mrsp.q;
                    if (mrsp.q != '0) begin
                        state_reg <= S_PRED; go_reg <= 1'b1;
                    end else state_reg <= S_RDA;
                end
                S_PRED: if (mrsp.done) begin
                    if (sub_reg == 5'd0) begin
                        px_reg <= lx_reg + q_s; sub_reg <= 5'd1; go_reg <= 1'b1;
                    end else begin
                        py_reg <= ly_reg + q_s; sub_reg <= '0; state_reg <= S_RDA;
                    end
                end
                S_RDA: begin
                    if (seg_reg + IW'(1) >= npts || npts < IW'(2)) state_reg <= S_FIN;
                    else state_reg <= S_RDB;
                end
                S_RDB: begin
                    bx_reg <= W'(signed'(rd_reg[23:0]));
                    by_reg <= W'(signed'(rd_reg[47:24]));
                    state_reg <= S_STR;
                end
                S_STR: begin
                    ax_reg <= W'(signed'(rd_reg[23:0]));
                    ay_reg <= W'(signed'(rd_reg[47:24]));
                    state_reg <= S_SEG; sub_reg <= '0; go_reg <= 1'b1;
                end
                S_SEG: if (mrsp.done) begin
                    go_reg <= 1'b1;
                    sub_reg <= sub_reg + 5'd1;
                    unique case (sub_reg)
                        5'd0: begin
                            len_reg <= mrsp.q;
                            nx_reg <= ax_reg; ny_reg <= ay_reg;
                            if (mrsp.q == '0) sub_reg <= 5'd4;
                        end
                        5'd1: t_reg <= q_s;
                        5'd2: nx_reg <= ax_reg + q_s;
                        5'd3: ny_reg <= ay_reg + q_s;
                        5'd4: m1_reg <= mrsp.q;
                        5'd5: if (m1_reg + mrsp.q > len_reg + ONE) begin
                            nx_reg <= bx_reg; ny_reg <= by_reg;
                        end
                        5'd6: begin
                            if (mrsp.q < rec_reg) begin
                                rec_reg <= mrsp.q;
                                tx_reg <= nx_reg; ty_reg <= ny_reg;
                                dx_reg <= '0; dy_reg <= '0;
                                if (len_reg == '0) begin
                                    go_reg <= 1'b0; state_reg <= S_RDA;
                                    seg_reg <= seg_reg + IW'(1);
                                end
                            end else begin
                                go_reg <= 1'b0; state_reg <= S_RDA;
                                seg_reg <= seg_reg + IW'(1);
                            end
                        end
                        5'd7: dx_reg <= q_s;
                        default: begin
                            dy_reg <= q_s; go_reg <= 1'b0; state_reg <= S_RDA;
                            seg_reg <= seg_reg + IW'(1);
                        end
                    endcase
                end
                S_FIN: begin
                    if (rec_reg > ONE) begin
                        steer_reg <= 1'b1; state_reg <= S_SEEK;
                        sub_reg <= '0; go_reg <= 1'b1;
                    end else state_reg <= S_OUT;
                end
                S_SEEK: if (mrsp.done) begin
                    if (sub_reg == 5'd0) begin
                        qd_reg <= mrsp.q;
                        if (mrsp.q == '0) state_reg <= S_OUT;
                        else begin sub_reg <= 5'd1; go_reg <= 1'b1; end
                    end else if (sub_reg == 5'd1) begin
                        sx_reg <= clampv(q_s - vx_reg, max_force_reg);
                        sub_reg <= 5'd2; go_reg <= 1'b1;
                    end else begin
                        sy_reg <= clampv(q_s - vy_reg, max_force_reg);
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    vx_reg <= nvx; vy_reg <= nvy;
                    lx_reg <= W'(signed'(24'(lx_reg + nvx)));
                    ly_reg <= W'(signed'(24'(ly_reg + nvy)));
                    out_data_reg <= {(rec_reg > W'(24'hFFFFFF)) ? 24'hFFFFFF : rec_reg[23:0],
                                     nvy[23:0], nvx[23:0],
                                     24'(ly_reg + nvy), 24'(lx_reg + nvx)};
                    out_user_reg <= steer_reg;
                    out_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int WATCHDOG_LIMIT = 400000;
    localparam int SETTLE_CYCLES  = 40;

    typedef struct {
        logic [23:0] loc_x;
        logic [23:0] loc_y;
        logic [23:0] vel_x;
        logic [23:0] vel_y;
        logic [23:0] distance;
        logic        steered;
    } agent_state_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [55:0]  s_tdata = '0;   // point_index[3:0], point_x, point_y, zero pad
    logic         s_tuser = 1'b0; // op
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [119:0] m_tdata;        // location_x, location_y, velocity_x, velocity_y,
                                  // distance_to_path
    logic         m_tuser;        // steered
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [4:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    path_following_steering_step u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // steering model state
    longint speed_limit = 512, force_limit = 26, path_len = 2;
    longint agent_x = 256256, agent_y = 166656, agent_vx = -512, agent_vy = 0;
    longint path_x[16], path_y[16];

    agent_state_t expected_states[$];
    int  error_count = 0;
    bit  steady_mode = 1'b0;
    int  sink_hold = 0;
    int  quiet_cycles = 0;

    function automatic longint wrap24(longint v);
        logic signed [23:0] t;
        t = v[23:0];
        return longint'(t);
    endfunction

    function automatic longint vec_length(longint dx, longint dy);
        longint unsigned v, r, b;
        v = longint'(dx * dx) + longint'(dy * dy);
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic longint limit_to(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic agent_state_t advance_agent(bit op, logic [3:0] idx,
                                                    longint ptx, longint pty);
        agent_state_t r;
        longint vm, px, py, record, tx, ty, dx, dy, stx, sty, n;
        longint ax, ay, bx, by, abx, aby, len, nx, ny, d, t, qx, qy, qd;
        bit steer;
        steer = 1'b0;
        record = 0;
        if (!op) begin
            path_x[idx] = ptx;
            path_y[idx] = pty;
        end else begin
            vm = vec_length(agent_vx, agent_vy);
            px = agent_x;
            py = agent_y;
            record = 64'sd1000000 * 256;
            tx = 0; ty = 0; dx = 0; dy = 0; stx = 0; sty = 0;
            n = (path_len > 16) ? 16 : path_len;
            if (vm > 0) begin
                px += agent_vx * (30 * 256) / vm;
                py += agent_vy * (30 * 256) / vm;
            end
            for (int i = 0; i + 1 < n; i++) begin
                ax = path_x[i]; ay = path_y[i];
                bx = path_x[i + 1]; by = path_y[i + 1];
                abx = bx - ax; aby = by - ay;
                len = vec_length(abx, aby);
                nx = ax; ny = ay;
                if (len > 0) begin
                    t = (abx * (px - ax) + aby * (py - ay)) / len;
                    nx = ax + abx * t / len;
                    ny = ay + aby * t / len;
                end
                if (vec_length(nx - ax, ny - ay) + vec_length(nx - bx, ny - by) > len + 256) begin
                    nx = bx; ny = by;
                end
                d = vec_length(px - nx, py - ny);
                if (d < record) begin
                    record = d;
                    tx = nx; ty = ny; dx = 0; dy = 0;
                    if (len > 0) begin
                        dx = abx * (5 * 256) / len;
                        dy = aby * (5 * 256) / len;
                    end
                end
            end
            if (record > 256) begin
                qx = tx + dx - agent_x;
                qy = ty + dy - agent_y;
                qd = vec_length(qx, qy);
                steer = 1'b1;
                if (qd > 0) begin
                    stx = limit_to(qx * speed_limit / qd - agent_vx, force_limit);
                    sty = limit_to(qy * speed_limit / qd - agent_vy, force_limit);
                end
            end
            agent_vx = limit_to(agent_vx + stx, speed_limit);
            agent_vy = limit_to(agent_vy + sty, speed_limit);
            agent_x = wrap24(agent_x + agent_vx);
            agent_y = wrap24(agent_y + agent_vy);
            if (record > 16777215) record = 16777215;
        end
        r.loc_x = agent_x[23:0];
        r.loc_y = agent_y[23:0];
        r.vel_x = agent_vx[23:0];
        r.vel_y = agent_vy[23:0];
        r.distance = record[23:0];
        r.steered = steer;
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [23:0] got, logic [23:0] want);
        $display("mismatch on %s: got %h, want %h at %0t", field, got, want, $realtime);
        error_count++;
    endtask

    always @(posedge aclk) begin
        agent_state_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_states.size() == 0) begin
                $display("unexpected result transaction at %0t", $realtime);
                error_count++;
            end else begin
                e = expected_states.pop_front();
                if (m_tdata[23:0] !== e.loc_x) report_mismatch("location_x", m_tdata[23:0], e.loc_x);
                if (m_tdata[47:24] !== e.loc_y) report_mismatch("location_y", m_tdata[47:24], e.loc_y);
                if (m_tdata[71:48] !== e.vel_x) report_mismatch("velocity_x", m_tdata[71:48], e.vel_x);
                if (m_tdata[95:72] !== e.vel_y) report_mismatch("velocity_y", m_tdata[95:72], e.vel_y);
                if (m_tdata[119:96] !== e.distance)
                    report_mismatch("distance", m_tdata[119:96], e.distance);
                if (m_tuser !== e.steered)
                    report_mismatch("steered", 24'(m_tuser), 24'(e.steered));
            end
        end
    end

    always @(posedge aclk) begin
        if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= steady_mode || ($urandom_range(99) >= 24);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_item(bit op, logic [3:0] idx, longint ptx, longint pty);
        while (!steady_mode && $urandom_range(99) < 24) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {4'b0, pty[23:0], ptx[23:0], idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_states.push_back(advance_agent(op, idx, ptx, pty));
    endtask

    task automatic drain;
        @(posedge aclk);
        s_tvalid <= 1'b0;
        while (expected_states.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(logic [2:0] index, longint value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value[31:0];
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (index)
            pfs_pkg::REG_MAX_SPEED:   speed_limit = value & 12'hFFF;
            pfs_pkg::REG_MAX_FORCE:   force_limit = value & 12'hFFF;
            pfs_pkg::REG_PATH_LENGTH: path_len = value & 5'h1F;
            default: ;
        endcase
    endtask

    function automatic longint near_coord(longint center);
        if ($urandom_range(9) == 0) return wrap24(longint'($urandom));
        return wrap24(center + longint'($urandom_range(40000)) - 20000);
    endfunction

    task automatic test_directed;
        for (int i = 0; i < 16; i++)
            send_item(1'b0, i[3:0], 256256 - 4096 * i, 166656 + ((i % 2) ? 2048 : -2048));
        send_item(1'b1, 4'd0, 0, 0);
        send_item(1'b1, 4'd0, 0, 0);
        drain();
        write_register(pfs_pkg::REG_PATH_LENGTH, 1);
        send_item(1'b1, 4'd0, 0, 0);
        drain();
        write_register(pfs_pkg::REG_PATH_LENGTH, 31);
        send_item(1'b1, 4'd0, 0, 0);
        drain();
        write_register(pfs_pkg::REG_PATH_LENGTH, 2);
        send_item(1'b0, 4'd1, 256256, 166656);
        send_item(1'b0, 4'd0, 256256, 166656);
        send_item(1'b1, 4'd0, 0, 0);
        send_item(1'b0, 4'd0, -8388608, 8388607);
        send_item(1'b0, 4'd1, 8388607, -8388608);
        send_item(1'b1, 4'd0, 0, 0);
        drain();
    endtask

    task automatic test_random(int count, longint speed, longint force_val, longint len);
        write_register(pfs_pkg::REG_MAX_SPEED, speed);
        write_register(pfs_pkg::REG_MAX_FORCE, force_val);
        write_register(pfs_pkg::REG_PATH_LENGTH, len);
        for (int i = 0; i < count; i++) begin
            steady_mode = (i >= count / 2) && (i < count / 2 + 15);
            if ($urandom_range(99) < 30)
                send_item(1'b0, 4'($urandom_range(15)), near_coord(agent_x), near_coord(agent_y));
            else
                send_item(1'b1, 4'($urandom), 0, 0);
        end
        steady_mode = 1'b0;
        drain();
    endtask

    task automatic test_backpressure;
        sink_hold = 600;
        for (int i = 0; i < 12; i++)
            send_item(1'b0, 4'($urandom_range(15)), near_coord(agent_x), near_coord(agent_y));
        drain();
    endtask

    task automatic test_start_registers;
        write_register(pfs_pkg::REG_START_X, -8388608);
        write_register(pfs_pkg::REG_START_Y, 8388607);
        send_item(1'b1, 4'd0, 0, 0);
        drain();
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_start_registers();
        test_random(45, 512, 26, 3);
        test_random(45, 4095, 4095, 2);
        test_random(45, 0, 0, 4);
        test_random(50, 1024, 200, 6);
        test_backpressure();
        test_random(40, 300, 13, 16);
        if (error_count == 0 && expected_states.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
